>>> hdl/cod_pkg.sv
// Shared constants and types for the consensus outcome decider.
// No dependencies; cod_pct_check and consensus_outcome_decider refer to this package by scoped name.
`timescale 1ns / 1ps

package cod_pkg;

   // default field widths
   localparam int COUNT_BITS_DEF = 10;
   localparam int TIME_BITS_DEF  = 24;

   // fixed register widths
   localparam int FACTOR_BITS = 8;
   localparam int PCT_BITS    = 7;

   // percentage scale
   localparam int PCT_SCALE = 100;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_CONSENSUS_MS     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_CONSENSUS_MS     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ABANDON_CONSENSUS_MS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ABANDON_FACTOR       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_CONSENSUS_PCT    = 3'd4;

   // register reset values
   localparam int RST_MIN_CONSENSUS_MS     = 1950;
   localparam int RST_MAX_CONSENSUS_MS     = 15000;
   localparam int RST_ABANDON_CONSENSUS_MS = 120000;
   localparam int RST_ABANDON_FACTOR       = 10;
   localparam int RST_MIN_CONSENSUS_PCT    = 80;

   typedef enum logic [1:0] {
      VERDICT_NO       = 2'd0,
      VERDICT_REACHED  = 2'd1,
      VERDICT_MOVED_ON = 2'd2,
      VERDICT_EXPIRED  = 2'd3
   } verdict_type;

   // qualifiers for one percentage test
   typedef struct packed {
      logic add_self;
      logic reached_max;
      logic stalled;
   } pct_ctl_type;

endpackage

>>> hdl/cod_if.sv
// Handshake channels of the consensus outcome decider: check items in, verdicts out.
// Does not depend on cod_pkg; widths are parameters.
`timescale 1ns / 1ps

interface cod_req_if #(
   parameter int COUNT_BITS = 10,
   parameter int TIME_BITS  = 24
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] prev_proposers;
   logic [COUNT_BITS-1:0] cur_proposers;
   logic [COUNT_BITS-1:0] agree_count;
   logic [COUNT_BITS-1:0] finished_count;
   logic [TIME_BITS-1:0]  prev_agree_ms;
   logic [TIME_BITS-1:0]  cur_agree_ms;
   logic                  is_stalled;
   logic                  is_proposing;

   modport source (
      output valid, prev_proposers, cur_proposers, agree_count, finished_count,
             prev_agree_ms, cur_agree_ms, is_stalled, is_proposing,
      input  ready
   );
   modport sink (
      input  valid, prev_proposers, cur_proposers, agree_count, finished_count,
             prev_agree_ms, cur_agree_ms, is_stalled, is_proposing,
      output ready
   );
endinterface

interface cod_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

>>> hdl/cod_pct_check.sv
// Exact percentage test by cross-multiplication, with the zero-peer and stalled rules.
// Depends on cod_pkg (pct_ctl_type, PCT_SCALE, PCT_BITS).
`timescale 1ns / 1ps

module cod_pct_check #(
   parameter int COUNT_BITS = cod_pkg::COUNT_BITS_DEF
) (
   input  logic [COUNT_BITS-1:0]        agreeing,
   input  logic [COUNT_BITS-1:0]        total,
   input  cod_pkg::pct_ctl_type         ctl,
   input  logic [cod_pkg::PCT_BITS-1:0] pct,
   output logic                         reached
);

   localparam int PROD_BITS = COUNT_BITS + 1 + cod_pkg::PCT_BITS;

   logic [COUNT_BITS:0]  agree_adj;
   logic [COUNT_BITS:0]  total_adj;
   logic [PROD_BITS-1:0] lhs;
   logic [PROD_BITS-1:0] rhs;

   // add self to both sides when proposing
   assign agree_adj = {1'b0, agreeing} + (COUNT_BITS+1)'(ctl.add_self);
   assign total_adj = {1'b0, total} + (COUNT_BITS+1)'(ctl.add_self);

   assign lhs = PROD_BITS'(agree_adj) * PROD_BITS'(cod_pkg::PCT_SCALE);
   assign rhs = PROD_BITS'(pct) * PROD_BITS'(total_adj);

   always_comb begin
      priority if (total == '0) begin
         reached = ctl.reached_max;
      end else if (ctl.stalled) begin
         reached = 1'b1;
      end else begin
         reached = (lhs >= rhs);
      end
   end

endmodule

>>> hdl/consensus_outcome_decider.sv
// Top level of the consensus outcome decider: input register, decision logic,
// result register and the configuration registers. Depends on cod_pkg, cod_if, cod_pct_check.
`timescale 1ns / 1ps

// Usage
//   req_ch carries one consensus check per item (proposer, agreeing and finished
//   counts, previous and current agreement times, stalled and proposing flags).
//   rsp_ch returns exactly one 2-bit verdict per item, in order: 0 no consensus,
//   1 reached, 2 moved on, 3 expired.
//   csr_wr_en/csr_index/csr_wdata write the five timing and percentage registers;
//   write them only while no item is in flight.
// Timing
//   The verdict is registered: an item accepted on req_ch passes through the input
//   register, then the result register, with the decision logic (three small
//   multipliers and a handful of compares) between them. One item is accepted
//   every cycle while rsp_ch is drained.
// Stall
//   When rsp_ch is not taken the verdict holds; one more item is taken into
//   the input register, after which req_ch.ready drops until the result moves.
// Reset
//   Synchronous, active high: both stages empty, registers back to defaults
//   (1950 ms, 15000 ms, 120000 ms, factor 10, 80 percent).

module consensus_outcome_decider #(
   parameter int COUNT_BITS = cod_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = cod_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   cod_req_if.sink                          req_ch,
   cod_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [cod_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]             csr_wdata
);

   localparam int FB        = cod_pkg::FACTOR_BITS;
   localparam int LIM_BITS  = TIME_BITS + FB;

   // configuration registers
   logic [TIME_BITS-1:0]         min_ms_ff;
   logic [TIME_BITS-1:0]         max_ms_ff;
   logic [TIME_BITS-1:0]         abandon_ms_ff;
   logic [FB-1:0]                factor_ff;
   logic [cod_pkg::PCT_BITS-1:0] pct_ff;

   // input stage
   logic                  in_vld_ff;
   logic [COUNT_BITS-1:0] prev_p_ff;
   logic [COUNT_BITS-1:0] cur_p_ff;
   logic [COUNT_BITS-1:0] agree_ff;
   logic [COUNT_BITS-1:0] fin_ff;
   logic [TIME_BITS-1:0]  prev_t_ff;
   logic [TIME_BITS-1:0]  cur_t_ff;
   logic                  stalled_ff;
   logic                  proposing_ff;

   // result stage
   logic                 out_vld_ff;
   cod_pkg::verdict_type verdict_ff;
   cod_pkg::verdict_type verdict_in;

   logic advance_out;
   logic take_req;

   // decision signals
   logic                  below_min;
   logic [COUNT_BITS+1:0] three_quarter;
   logic [TIME_BITS:0]    wait_until;
   logic                  few_proposers;
   logic                  reached_max;
   logic                  agree_ok;
   logic                  moved_ok;
   logic [LIM_BITS-1:0]   limit_full;
   logic [TIME_BITS-1:0]  limit_sat;
   logic [TIME_BITS-1:0]  limit;
   cod_pkg::pct_ctl_type  agree_ctl;
   cod_pkg::pct_ctl_type  moved_ctl;

   // handshake
   assign advance_out  = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = !in_vld_ff || advance_out;
   assign take_req     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid   = out_vld_ff;
   assign rsp_ch.verdict = verdict_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ms_ff     <= TIME_BITS'(cod_pkg::RST_MIN_CONSENSUS_MS);
         max_ms_ff     <= TIME_BITS'(cod_pkg::RST_MAX_CONSENSUS_MS);
         abandon_ms_ff <= TIME_BITS'(cod_pkg::RST_ABANDON_CONSENSUS_MS);
         factor_ff     <= FB'(cod_pkg::RST_ABANDON_FACTOR);
         pct_ff        <= cod_pkg::PCT_BITS'(cod_pkg::RST_MIN_CONSENSUS_PCT);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cod_pkg::CSR_MIN_CONSENSUS_MS:     min_ms_ff     <= csr_wdata;
            cod_pkg::CSR_MAX_CONSENSUS_MS:     max_ms_ff     <= csr_wdata;
            cod_pkg::CSR_ABANDON_CONSENSUS_MS: abandon_ms_ff <= csr_wdata;
            cod_pkg::CSR_ABANDON_FACTOR:       factor_ff     <= csr_wdata[FB-1:0];
            cod_pkg::CSR_MIN_CONSENSUS_PCT:    pct_ff <= csr_wdata[cod_pkg::PCT_BITS-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         prev_p_ff    <= req_ch.prev_proposers;
         cur_p_ff     <= req_ch.cur_proposers;
         agree_ff     <= req_ch.agree_count;
         fin_ff       <= req_ch.finished_count;
         prev_t_ff    <= req_ch.prev_agree_ms;
         cur_t_ff     <= req_ch.cur_agree_ms;
         stalled_ff   <= req_ch.is_stalled;
         proposing_ff <= req_ch.is_proposing;
      end
   end

   // minimum gate and few-proposers wait
   assign below_min     = (cur_t_ff <= min_ms_ff);
   assign three_quarter = ({2'b00, prev_p_ff} + {1'b0, prev_p_ff, 1'b0}) >> 2;
   assign wait_until    = {1'b0, prev_t_ff} + {1'b0, min_ms_ff};
   assign few_proposers = ({2'b00, cur_p_ff} < three_quarter)
                          && ({1'b0, cur_t_ff} < wait_until);
   assign reached_max   = (cur_t_ff > max_ms_ff);

   assign agree_ctl = '{add_self: proposing_ff, reached_max: reached_max,
                        stalled: stalled_ff};
   assign moved_ctl = '{add_self: 1'b0, reached_max: reached_max, stalled: 1'b0};

   cod_pct_check #(.COUNT_BITS(COUNT_BITS)) u_agree_check (
      .agreeing (agree_ff),
      .total    (cur_p_ff),
      .ctl      (agree_ctl),
      .pct      (pct_ff),
      .reached  (agree_ok)
   );

   cod_pct_check #(.COUNT_BITS(COUNT_BITS)) u_moved_check (
      .agreeing (fin_ff),
      .total    (cur_p_ff),
      .ctl      (moved_ctl),
      .pct      (pct_ff),
      .reached  (moved_ok)
   );

   // expiry limit: saturate the product, then clamp low first, high second
   assign limit_full = LIM_BITS'(prev_t_ff) * LIM_BITS'(factor_ff);
   assign limit_sat  = (|limit_full[LIM_BITS-1:TIME_BITS]) ? '1
                                                            : limit_full[TIME_BITS-1:0];

   always_comb begin
      priority if (limit_sat < max_ms_ff) begin
         limit = max_ms_ff;
      end else if (limit_sat > abandon_ms_ff) begin
         limit = abandon_ms_ff;
      end else begin
         limit = limit_sat;
      end
   end

   always_comb begin
      priority if (below_min || few_proposers) begin
         verdict_in = cod_pkg::VERDICT_NO;
      end else if (agree_ok) begin
         verdict_in = cod_pkg::VERDICT_REACHED;
      end else if (moved_ok) begin
         verdict_in = cod_pkg::VERDICT_MOVED_ON;
      end else if (cur_t_ff > limit) begin
         verdict_in = cod_pkg::VERDICT_EXPIRED;
      end else begin
         verdict_in = cod_pkg::VERDICT_NO;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance_out) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_out && in_vld_ff) begin
         verdict_ff <= verdict_in;
      end
   end

   // checks
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      take_req |=> in_vld_ff)
      else $error("accepted item did not reach the input register");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && advance_out) |=> out_vld_ff)
      else $error("item in the input register was lost on its way to the result");

   a_min_gate: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && advance_out && below_min) |=> (verdict_ff == cod_pkg::VERDICT_NO))
      else $error("verdict other than no consensus below the minimum time");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance_out) |=> (in_vld_ff && $stable(cur_t_ff)))
      else $error("input register changed while the result stage was stalled");

endmodule

>>> dv/consensus_outcome_decider_tb.sv
// Self-checking testbench for consensus_outcome_decider: directed and random consensus
// checks under several register settings, verdicts predicted in-line and compared in order.
// Depends on cod_pkg, cod_if and the RTL of the block.
`timescale 1ns / 1ps

module consensus_outcome_decider_tb;

   localparam int COUNT_BITS = cod_pkg::COUNT_BITS_DEF;
   localparam int TIME_BITS  = cod_pkg::TIME_BITS_DEF;
   localparam int FACT_BITS  = cod_pkg::FACTOR_BITS;
   localparam int PCT_W      = cod_pkg::PCT_BITS;
   localparam int IDX_BITS   = cod_pkg::CSR_IDX_BITS;
   localparam int PROD_W     = COUNT_BITS + PCT_W + 2;
   localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam longint TIME_MAX  = (64'd1 << TIME_BITS) - 1;
   localparam logic [IDX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam longint TIMEOUT_NS = 64'd6_000_000;

   typedef struct packed {
      logic [COUNT_BITS-1:0] prev_proposers;
      logic [COUNT_BITS-1:0] cur_proposers;
      logic [COUNT_BITS-1:0] agree_count;
      logic [COUNT_BITS-1:0] finished_count;
      logic [TIME_BITS-1:0]  prev_agree_ms;
      logic [TIME_BITS-1:0]  cur_agree_ms;
      logic                  is_stalled;
      logic                  is_proposing;
   } consensus_check_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] min_ms;
      logic [TIME_BITS-1:0] max_ms;
      logic [TIME_BITS-1:0] abandon_ms;
      logic [FACT_BITS-1:0] factor;
      logic [PCT_W-1:0]     pct;
   } timing_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [IDX_BITS-1:0]  csr_index;
   logic [TIME_BITS-1:0] csr_wdata;

   cod_req_if #(.COUNT_BITS(COUNT_BITS), .TIME_BITS(TIME_BITS)) req_ch ();
   cod_rsp_if rsp_ch ();

   consensus_outcome_decider #(
      .COUNT_BITS(COUNT_BITS),
      .TIME_BITS (TIME_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch.sink),
      .rsp_ch   (rsp_ch.source),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   consensus_check_type  checks_pending[$];
   cod_pkg::verdict_type verdicts_due[$];
   timing_cfg_type       cfg;
   cod_pkg::verdict_type awaited;
   int fail_count    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap      = 0;
   int recv_gap      = 0;
   bit hold_go       = 1'b0;
   bit rsp_holding   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.prev_proposers = '0;
      req_ch.cur_proposers  = '0;
      req_ch.agree_count    = '0;
      req_ch.finished_count = '0;
      req_ch.prev_agree_ms  = '0;
      req_ch.cur_agree_ms   = '0;
      req_ch.is_stalled     = 1'b0;
      req_ch.is_proposing   = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   // long receiver hold-off, so the block fills and stalls its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_holding <= 1'b0;
   end

   function automatic bit share_met(logic [COUNT_BITS:0] part, logic [COUNT_BITS:0] whole,
                                    logic [PCT_W-1:0] pct);
      logic [PROD_W-1:0] lhs;
      logic [PROD_W-1:0] rhs;
      lhs = PROD_W'(part) * PROD_W'(cod_pkg::PCT_SCALE);
      rhs = PROD_W'(pct) * PROD_W'(whole);
      return lhs >= rhs;
   endfunction

   function automatic cod_pkg::verdict_type predict_verdict(consensus_check_type c,
                                                            timing_cfg_type k);
      logic [COUNT_BITS+1:0]          three_quarters;
      logic [TIME_BITS:0]             settle_end;
      logic [TIME_BITS+FACT_BITS-1:0] scaled;
      logic [TIME_BITS-1:0]           expiry;
      logic [COUNT_BITS:0]            backers;
      logic [COUNT_BITS:0]            voters;
      logic                           past_max;
      if (c.cur_agree_ms <= k.min_ms) return cod_pkg::VERDICT_NO;
      three_quarters = ({2'b00, c.prev_proposers} * (COUNT_BITS+2)'(3)) >> 2;
      settle_end = {1'b0, c.prev_agree_ms} + {1'b0, k.min_ms};
      if ({2'b00, c.cur_proposers} < three_quarters &&
          {1'b0, c.cur_agree_ms} < settle_end) return cod_pkg::VERDICT_NO;
      past_max = c.cur_agree_ms > k.max_ms;
      if (c.cur_proposers == 0) begin
         if (past_max) return cod_pkg::VERDICT_REACHED;
      end else if (c.is_stalled) begin
         return cod_pkg::VERDICT_REACHED;
      end else begin
         // a proposing node counts itself on both sides
         backers = {1'b0, c.agree_count} + (COUNT_BITS+1)'(c.is_proposing);
         voters  = {1'b0, c.cur_proposers} + (COUNT_BITS+1)'(c.is_proposing);
         if (share_met(backers, voters, k.pct)) return cod_pkg::VERDICT_REACHED;
      end
      if (c.cur_proposers == 0 ? past_max
          : share_met({1'b0, c.finished_count}, {1'b0, c.cur_proposers}, k.pct))
         return cod_pkg::VERDICT_MOVED_ON;
      scaled = (TIME_BITS+FACT_BITS)'(c.prev_agree_ms) * (TIME_BITS+FACT_BITS)'(k.factor);
      expiry = (|scaled[TIME_BITS+FACT_BITS-1:TIME_BITS]) ? '1 : scaled[TIME_BITS-1:0];
      if (expiry < k.max_ms) expiry = k.max_ms;
      else if (expiry > k.abandon_ms) expiry = k.abandon_ms;
      return (c.cur_agree_ms > expiry) ? cod_pkg::VERDICT_EXPIRED : cod_pkg::VERDICT_NO;
   endfunction

   function automatic logic [COUNT_BITS-1:0] near_count(longint centre);
      longint n;
      n = centre + longint'($urandom_range(0, 4)) - 2;
      if (n < 0) n = 0;
      else if (n > COUNT_MAX) n = COUNT_MAX;
      return n[COUNT_BITS-1:0];
   endfunction

   function automatic logic [TIME_BITS-1:0] near_time(longint centre);
      longint t;
      t = centre + longint'($urandom_range(0, 6)) - 3;
      if (t < 0) t = 0;
      else if (t > TIME_MAX) t = TIME_MAX;
      return t[TIME_BITS-1:0];
   endfunction

   // mostly checks that sit near one of the decision thresholds, some pure noise
   function automatic consensus_check_type shaped_check(timing_cfg_type k);
      consensus_check_type c;
      logic [95:0]         noise;
      longint              need;
      noise = {$urandom, $urandom, $urandom};
      c = noise[$bits(consensus_check_type)-1:0];
      if ($urandom_range(0, 4) == 0) return c;
      if ($urandom_range(0, 3) != 0) c.prev_proposers = COUNT_BITS'($urandom_range(0, 40));
      case ($urandom_range(0, 5))
         0: c.cur_proposers = '0;
         1, 2: c.cur_proposers = near_count((longint'(c.prev_proposers) * 3) / 4);
         3: c.cur_proposers = near_count(longint'(c.prev_proposers));
         default: ;
      endcase
      c.is_stalled = ($urandom_range(0, 5) == 0);
      need = (longint'(k.pct) * longint'(c.cur_proposers) + 99) / 100;
      if ($urandom_range(0, 4) != 0)
         c.agree_count = near_count(need - longint'(c.is_proposing));
      if ($urandom_range(0, 4) != 0) c.finished_count = near_count(need);
      if ($urandom_range(0, 3) != 0) c.prev_agree_ms = TIME_BITS'($urandom_range(0, 40000));
      case ($urandom_range(0, 6))
         0: c.cur_agree_ms = near_time(longint'(k.min_ms));
         1: c.cur_agree_ms = near_time(longint'(k.max_ms));
         2: c.cur_agree_ms = near_time(longint'(k.abandon_ms));
         3: c.cur_agree_ms = near_time(longint'(c.prev_agree_ms) * longint'(k.factor));
         4: c.cur_agree_ms = near_time(longint'(c.prev_agree_ms) + longint'(k.min_ms));
         5: c.cur_agree_ms = TIME_BITS'($urandom_range(0, 200000));
         default: ;
      endcase
      return c;
   endfunction

   function automatic timing_cfg_type cfg_of(longint min_ms, longint max_ms,
                                             longint abandon_ms, int factor, int pct);
      timing_cfg_type k;
      k.min_ms     = min_ms[TIME_BITS-1:0];
      k.max_ms     = max_ms[TIME_BITS-1:0];
      k.abandon_ms = abandon_ms[TIME_BITS-1:0];
      k.factor     = factor[FACT_BITS-1:0];
      k.pct        = pct[PCT_W-1:0];
      return k;
   endfunction

   function automatic timing_cfg_type random_cfg();
      return cfg_of(($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'(TIME_MAX))
                                                : $urandom_range(0, 4000),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'(TIME_MAX))
                                                : $urandom_range(0, 40000),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'(TIME_MAX))
                                                : $urandom_range(0, 300000),
                    $urandom_range(0, 255),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(50, 100));
   endfunction

   task automatic write_register(logic [IDX_BITS-1:0] index, logic [TIME_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         cod_pkg::CSR_MIN_CONSENSUS_MS:     cfg.min_ms     = value;
         cod_pkg::CSR_MAX_CONSENSUS_MS:     cfg.max_ms     = value;
         cod_pkg::CSR_ABANDON_CONSENSUS_MS: cfg.abandon_ms = value;
         cod_pkg::CSR_ABANDON_FACTOR:       cfg.factor     = value[FACT_BITS-1:0];
         cod_pkg::CSR_MIN_CONSENSUS_PCT:    cfg.pct        = value[PCT_W-1:0];
         default: ;
      endcase
   endtask

   // junk in the upper bits of the narrow registers must be dropped by the block
   task automatic apply_config(timing_cfg_type k);
      logic [31:0] junk;
      junk = $urandom;
      write_register(cod_pkg::CSR_MIN_CONSENSUS_MS, k.min_ms);
      write_register(cod_pkg::CSR_MAX_CONSENSUS_MS, k.max_ms);
      write_register(cod_pkg::CSR_ABANDON_CONSENSUS_MS, k.abandon_ms);
      write_register(cod_pkg::CSR_ABANDON_FACTOR, {junk[15:0], k.factor});
      write_register(cod_pkg::CSR_MIN_CONSENSUS_PCT, {junk[31:15], k.pct});
      write_register(CSR_SPARE_INDEX, junk[23:0]);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_check(int pp, int cp, int ac, int fc, longint pt, longint ct,
                            bit st, bit pr);
      consensus_check_type c;
      c.prev_proposers = pp[COUNT_BITS-1:0];
      c.cur_proposers  = cp[COUNT_BITS-1:0];
      c.agree_count    = ac[COUNT_BITS-1:0];
      c.finished_count = fc[COUNT_BITS-1:0];
      c.prev_agree_ms  = pt[TIME_BITS-1:0];
      c.cur_agree_ms   = ct[TIME_BITS-1:0];
      c.is_stalled     = st;
      c.is_proposing   = pr;
      checks_pending.push_back(c);
   endtask

   task automatic add_random(int count);
      repeat (count) checks_pending.push_back(shaped_check(cfg));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (checks_pending.size() != 0 || verdicts_due.size() != 0);
   endtask

   // driver: offer the oldest pending check, predict its verdict once taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            verdicts_due.push_back(predict_verdict(checks_pending.pop_front(), cfg));
         end
         // an item on offer but not taken is held as it is
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (checks_pending.size() != 0 &&
                         $urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 10);
               req_ch.valid <= 1'b0;
            end else if (checks_pending.size() != 0) begin
               req_ch.prev_proposers <= checks_pending[0].prev_proposers;
               req_ch.cur_proposers  <= checks_pending[0].cur_proposers;
               req_ch.agree_count    <= checks_pending[0].agree_count;
               req_ch.finished_count <= checks_pending[0].finished_count;
               req_ch.prev_agree_ms  <= checks_pending[0].prev_agree_ms;
               req_ch.cur_agree_ms   <= checks_pending[0].cur_agree_ms;
               req_ch.is_stalled     <= checks_pending[0].is_stalled;
               req_ch.is_proposing   <= checks_pending[0].is_proposing;
               req_ch.valid          <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: take verdicts and compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdicts_due.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: verdict %b arrived with none expected", $time, rsp_ch.verdict);
               fail_count++;
            end else begin
               awaited = verdicts_due.pop_front();
               if (rsp_ch.verdict !== awaited) begin
                  if (fail_count < MAX_REPORTS)
                     $display("%0t: verdict mismatch: expected %s (%0d) actual %b",
                              $time, awaited.name(), awaited, rsp_ch.verdict);
                  fail_count++;
               end
            end
         end
         if (rsp_holding) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      cfg = cfg_of(longint'(cod_pkg::RST_MIN_CONSENSUS_MS),
                   longint'(cod_pkg::RST_MAX_CONSENSUS_MS),
                   longint'(cod_pkg::RST_ABANDON_CONSENSUS_MS),
                   cod_pkg::RST_ABANDON_FACTOR, cod_pkg::RST_MIN_CONSENSUS_PCT);
      do @(negedge clock);
      while (reset);

      // reset settings: gate, few proposers, zero peers, self count, expiry clamps
      send_idle_pct = 25;
      recv_idle_pct = 25;
      add_check(0, 0, 0, 0, 0, 0, 0, 0);
      add_check(10, 10, 10, 0, 0, 1950, 0, 0);
      add_check(10, 10, 10, 0, 0, 1951, 0, 0);
      add_check(1023, 1023, 1023, 1023, TIME_MAX, TIME_MAX, 1, 1);
      add_check(0, 0, 0, 0, 0, 15000, 0, 0);
      add_check(0, 0, 0, 0, 0, 15001, 0, 1);
      add_check(100, 74, 74, 74, 3000, 4949, 0, 0);
      add_check(100, 74, 74, 74, 3000, 4950, 0, 0);
      add_check(100, 75, 0, 0, 3000, 2000, 0, 0);
      add_check(20, 4, 3, 0, 0, 2000, 0, 1);
      add_check(20, 4, 3, 0, 0, 2000, 0, 0);
      add_check(20, 10, 1, 10, 0, 2000, 0, 0);
      add_check(20, 10, 1, 7, 0, 2000, 1, 0);
      add_check(10, 10, 0, 0, 1000, 15000, 0, 0);
      add_check(10, 10, 0, 0, 1000, 15001, 0, 0);
      add_check(10, 10, 0, 0, 20000, 120000, 0, 0);
      add_check(10, 10, 0, 0, 20000, 120001, 0, 0);
      add_check(10, 5, 900, 0, 0, 2000, 0, 0);
      add_check(1023, 0, 0, 0, TIME_MAX, TIME_MAX, 0, 0);
      add_random(150);
      wait_drained();

      // sender keeps offering while the receiver holds off
      send_idle_pct = 0;
      add_random(160);
      hold_go = 1'b1;
      wait_drained();

      // sender pauses mid-phase until every verdict is back
      send_idle_pct = 30;
      add_random(40);
      wait_drained();
      add_random(40);
      wait_drained();

      apply_config(cfg_of(0, 0, 0, 0, 0));
      add_random(120);
      wait_drained();

      apply_config(cfg_of(TIME_MAX, TIME_MAX, TIME_MAX, 255, 127));
      add_random(60);
      wait_drained();

      // saturated expiry product against the widest clamp
      apply_config(cfg_of(0, 0, TIME_MAX, 255, 100));
      add_check(10, 10, 0, 0, 65794, TIME_MAX, 0, 0);
      add_check(10, 10, 0, 0, 65792, TIME_MAX, 0, 0);
      add_random(100);
      wait_drained();

      // crossed clamp bounds and a percentage above one hundred
      apply_config(cfg_of(0, 50000, 20000, 10, 127));
      add_check(10, 10, 0, 0, 100, 50001, 0, 0);
      add_check(10, 10, 0, 0, 10000, 20000, 0, 0);
      add_check(10, 10, 0, 0, 10000, 20001, 0, 0);
      add_check(10, 10, 10, 10, 0, 2000, 0, 1);
      add_check(0, 0, 0, 0, 0, 50001, 0, 0);
      add_random(100);
      wait_drained();

      repeat (7) begin
         send_idle_pct = $urandom_range(0, 2) * 20;
         recv_idle_pct = $urandom_range(0, 2) * 20;
         apply_config(random_cfg());
         add_random(110);
         wait_drained();
      end

      // closing stretch at full rate
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_config(cfg_of(longint'(cod_pkg::RST_MIN_CONSENSUS_MS),
                          longint'(cod_pkg::RST_MAX_CONSENSUS_MS),
                          longint'(cod_pkg::RST_ABANDON_CONSENSUS_MS),
                          cod_pkg::RST_ABANDON_FACTOR, cod_pkg::RST_MIN_CONSENSUS_PCT));
      add_random(200);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (verdicts_due.size() != 0) begin
         $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
